// File: rtl/core/brake_step_interpolator_defines.svh
// assertion macros for the brake step interpolator
`ifndef BRAKE_STEP_INTERPOLATOR_DEFINES_SVH
`define BRAKE_STEP_INTERPOLATOR_DEFINES_SVH

// implication checked at every clock edge outside reset
`define BSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define BSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/bsi_pkg.sv
// ----------------------------------------------------------------------------
// bsi_pkg
// Types and constants shared by the brake step interpolator.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int unsigned PedalThreshold = 328;
  localparam int unsigned PedalSpan      = 32440;
  localparam int unsigned StepMax        = 32767;

  // x*32768/32440 = x + x*41/4055; 41*ceil(2^34/4055) with a shift by 34
  // gives the last term exactly for x below 2^17
  localparam logic [27:0] SpanRecip = 28'd173705233;
  localparam int unsigned SpanShift = 34;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LOW_SPEED     = 3'd0,
    REG_HIGH_SPEED    = 3'd1,
    REG_LOW_FULL      = 3'd2,
    REG_HIGH_FULL     = 3'd3,
    REG_IDLE_STEP     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] low_speed;
    logic [14:0] high_speed;
    logic [14:0] low_full;
    logic [14:0] high_full;
    logic [14:0] idle_step;
  } cfg_t;

  // per-beat payload carried down the chain of cells
  typedef struct packed {
    logic               vld;
    logic signed [16:0] s;          // speed, sign-extended
    logic        [14:0] pedal;
    logic               low_pedal;
    logic signed [16:0] full;       // full step, may lie outside 0..32767
    logic               full_done;  // full step settled without interpolation
    logic signed [47:0] acc;        // working product or quotient
    logic signed [16:0] dnum;       // divider remainder
  } beat_t;

endpackage

// File: rtl/core/bsi_stream_if.sv
// ----------------------------------------------------------------------------
// bsi_stream_if
// Valid/ready channel carrying one payload of parametric width.
// ----------------------------------------------------------------------------
interface bsi_stream_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bsi_div_cell.sv
// ----------------------------------------------------------------------------
// bsi_div_cell
// One restoring-division step on magnitudes: shift in a quotient bit.
// ----------------------------------------------------------------------------
module bsi_div_cell #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] num_o,
  output logic [DW:0]   rem_o
);
  logic [DW+1:0] trial;
  logic [DW:0]   rem_nxt;
  logic [NW-1:0] num_nxt;

  // trial subtract of the shifted remainder
  always_comb begin
    trial   = {rem_i, num_i[NW-1]} - {2'b00, den};
    if (!trial[DW+1]) begin
      rem_nxt = trial[DW:0];
      num_nxt = {num_i[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_i[DW-1:0], num_i[NW-1]};
      num_nxt = {num_i[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= num_nxt;
      rem_o <= rem_nxt;
    end
  end
endmodule

// File: rtl/core/bsi_div_chain.sv
// ----------------------------------------------------------------------------
// bsi_div_chain
// Pipelined unsigned divider: a row of division cells, one quotient bit each,
// with a side payload of SW bits travelling alongside.
// ----------------------------------------------------------------------------
module bsi_div_chain #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [NW-1:0] num_q  [NW+1];
  logic [DW:0]   rem_q  [NW+1];
  logic [DW-1:0] den_q  [NW+1];
  logic [SW-1:0] side_q [NW+1];

  assign num_q[0]  = num_i;
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  // one cell per quotient bit
  for (genvar i = 0; i < NW; i++) begin : g_cell
    bsi_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk   (clk),
      .en    (en),
      .num_i (num_q[i]),
      .rem_i (rem_q[i]),
      .den   (den_q[i]),
      .num_o (num_q[i+1]),
      .rem_o (rem_q[i+1])
    );
    // side payload is cleared at reset so its valid bit starts low
    always_ff @(posedge clk) begin
      if (!rst_n) side_q[i+1] <= '0;
      else if (en) side_q[i+1] <= side_q[i];
      if (en) den_q[i+1] <= den_q[i];
    end
  end

  assign quo_o  = num_q[NW];
  assign side_o = side_q[NW];
endmodule

// File: rtl/core/brake_step_interpolator.sv
// ----------------------------------------------------------------------------
// brake_step_interpolator
// Maps speed and brake pedal to a saturated brake drive step.
// ----------------------------------------------------------------------------
// Usage:
//   in channel carries speed (16-bit signed) and brake_pedal (15-bit Q15);
//   out channel carries step_out (15-bit, 0..32767), one beat per input beat.
//   cfg_we/cfg_idx/cfg_wdata write the five 15-bit registers; write only
//   while the block is empty.
// Throughput: one beat per cycle, back to back, while the receiver does not stall.
// Pipeline: 33 division cells for the speed slope and offset (two chains
//   side by side), then the slope product, the pedal-span reciprocal
//   product, the pedal product and the saturating output register.
// The whole pipeline advances only when its last stage is free or taken, so
//   a stall at the receiver freezes every stage; in_ready follows it.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
//   register reset values (high_speed all ones, others zero).
// ----------------------------------------------------------------------------
module brake_step_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  bsi_stream_if.sink   in_if,
  bsi_stream_if.source out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [14:0] cfg_wdata
);
  import bsi_pkg::*;

  localparam int unsigned NW  = 33;  // magnitude width for both divisions
  localparam int unsigned DW  = 15;
  localparam int unsigned SW1 = 17 + 15 + 17 + 1 + 1 + 1;

  cfg_t cfg_r;
  logic en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{low_speed: '0, high_speed: 15'h7fff, low_full: '0,
                 high_full: '0, idle_step: '0};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LOW_SPEED:  cfg_r.low_speed  <= cfg_wdata;
        REG_HIGH_SPEED: cfg_r.high_speed <= cfg_wdata;
        REG_LOW_FULL:   cfg_r.low_full   <= cfg_wdata;
        REG_HIGH_FULL:  cfg_r.high_full  <= cfg_wdata;
        REG_IDLE_STEP:  cfg_r.idle_step  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: decode speed window, compute numerators of slope and offset
  logic signed [16:0] s0;
  logic [15:0]        mag0;
  logic               done0;
  logic signed [16:0] full0;
  logic signed [16:0] hsls0;
  logic [32:0]        knum0;
  logic               kneg0;
  logic [14:0]        den0;
  logic signed [31:0] cnum0;

  always_comb begin
    s0    = {in_if.data[15], in_if.data[15:0]};
    mag0  = s0[16] ? 16'(-s0) : s0[15:0];
    hsls0 = $signed({2'b00, cfg_r.high_full}) - $signed({2'b00, cfg_r.low_full});
    done0 = 1'b1;
    full0 = $signed({2'b00, cfg_r.low_full});
    if ({1'b0, mag0} < {2'b00, cfg_r.low_speed}) begin
      full0 = $signed({2'b00, cfg_r.low_full});
    end else if ({1'b0, mag0} > {2'b00, cfg_r.high_speed}) begin
      full0 = $signed({2'b00, cfg_r.high_full});
    end else if (cfg_r.high_speed == cfg_r.low_speed) begin
      full0 = $signed({2'b00, cfg_r.low_full});
    end else begin
      done0 = 1'b0;
    end
    // the negative-speed test s > -lo is identical to mag < lo, and
    // s < -hi matches mag > hi
    kneg0 = hsls0[16];
    knum0 = {(hsls0[16] ? 16'(-hsls0) : hsls0[15:0]), 15'd0} & {33{1'b1}};
    den0  = cfg_r.high_speed - cfg_r.low_speed;
    cnum0 = 32'(cfg_r.low_full) * 32'(cfg_r.high_speed)
          - 32'(cfg_r.high_full) * 32'(cfg_r.low_speed);
  end

  // c is divided separately below, with its sign as side data; both
  // divisions share the same divisor, so one chain carries k and a
  // second chain of the same width carries c
  logic [32:0]    kq;
  logic [32:0]    cq;
  logic [SW1-1:0] side1_i, side1_o;
  logic           vld0, vld1;

  assign vld0    = in_if.valid & in_if.ready;
  assign side1_i = {s0, in_if.data[30:16], full0, done0, kneg0, vld0};

  bsi_div_chain #(.NW(NW), .DW(DW), .SW(SW1)) u_kdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .num_i  (knum0),
    .den_i  (den0 == '0 ? 15'd1 : den0),
    .side_i (side1_i),
    .quo_o  (kq),
    .side_o (side1_o)
  );

  logic cneg_in, cneg_out;
  logic [32:0] cmag0;
  assign cneg_in = cnum0[31];
  assign cmag0   = {1'b0, (cnum0[31] ? 32'(-cnum0) : cnum0)};

  bsi_div_chain #(.NW(NW), .DW(DW), .SW(1)) u_cdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .num_i  (cmag0),
    .den_i  (den0 == '0 ? 15'd1 : den0),
    .side_i (cneg_in),
    .quo_o  (cq),
    .side_o (cneg_out)
  );

  // unpack after first division
  logic signed [16:0] s1, full1;
  logic [14:0]        pedal1;
  logic               done1, kneg1;
  assign {s1, pedal1, full1} = side1_o[SW1-1:3];
  assign done1 = side1_o[2];
  assign kneg1 = side1_o[1];
  assign vld1  = side1_o[0];

  // stage m1: k*s product register
  logic signed [49:0] ks_r;
  logic signed [33:0] c_r;
  logic signed [16:0] full_r1;
  logic               done_r1, vld_r1;
  logic [14:0]        pedal_r1;
  logic signed [33:0] k1;

  always_comb begin
    k1   = kneg1 ? -$signed({1'b0, kq}) : $signed({1'b0, kq});
    if (s1[16]) k1 = -k1;  // negated slope for negative speed
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r1 <= 1'b0;
    else if (en) vld_r1 <= vld1;
    if (en) begin
      ks_r     <= 50'(k1) * 50'(s1);
      c_r      <= cneg_out ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
      full_r1  <= full1;
      done_r1  <= done1;
      pedal_r1 <= pedal1;
    end
  end

  // stage m2: full step and distance from the idle step
  logic signed [16:0] full2;
  logic signed [17:0] d2;
  logic [16:0]        tx2;

  always_comb begin
    full2 = done_r1 ? full_r1 : 17'(($signed(ks_r) >>> 15) + c_r);
    d2    = $signed({full2[16], full2}) - $signed({3'b000, cfg_r.idle_step});
    tx2   = d2[17] ? 17'(-d2) : d2[16:0];
  end

  // reciprocal product for the division by the pedal span
  logic [16:0] tx_r;
  logic [44:0] tprod_r;
  logic [14:0] pedal_r2, base_r2;
  logic        tneg_r2, vld_r2;
  logic [32:0] tq;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r2 <= 1'b0;
    else if (en) vld_r2 <= vld_r1;
    if (en) begin
      tx_r     <= tx2;
      tprod_r  <= 45'(tx2) * 45'(SpanRecip);
      pedal_r2 <= pedal_r1;
      base_r2  <= cfg_r.idle_step;
      tneg_r2  <= d2[17];
    end
  end

  assign tq = 33'(tx_r) + 33'(tprod_r[44:SpanShift]);

  // stage m3: pedal product
  logic signed [49:0] tp_r;
  logic [14:0]        base_r3;
  logic               vld_r3, low_r3;
  logic signed [33:0] t3;
  logic signed [15:0] pe3;

  always_comb begin
    t3  = tneg_r2 ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    pe3 = $signed({1'b0, pedal_r2}) - 16'sd328;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r3 <= 1'b0;
    else if (en) vld_r3 <= vld_r2;
    if (en) begin
      tp_r    <= 50'(t3 * pe3);
      base_r3 <= base_r2;
      low_r3  <= pedal_r2 < 15'(PedalThreshold);
    end
  end

  // output register with saturation; a low pedal selects the idle step
  logic signed [35:0] r4;
  logic [14:0]        step_r;
  logic               ovld_r;

  always_comb begin
    r4 = 36'($signed(tp_r) >>> 15) + $signed({21'd0, base_r3});
  end

  assign en = !ovld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= vld_r3;
    if (en) begin
      if (low_r3)                        step_r <= base_r3;
      else if (r4 < 0)                   step_r <= '0;
      else if (r4 > 36'sd32767)          step_r <= 15'(StepMax);
      else                               step_r <= r4[14:0];
    end
  end

  assign in_if.ready  = en;
  assign out_if.valid = ovld_r;
  assign out_if.data  = step_r;
endmodule

// File: rtl/core/bsi_checker.sv
// ----------------------------------------------------------------------------
// bsi_checker
// Port-level checks on the brake step interpolator.
// ----------------------------------------------------------------------------
`include "brake_step_interpolator_defines.svh"

module bsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_data
);
  // stalled result holds its value
  `BSI_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  // stalled result stays valid
  `BSI_ASSERT_NXT(a_keep, clk, rst_n, out_valid && !out_ready, out_valid)
  // input ready is high exactly when the output side can move
  `BSI_ASSERT_IMP(a_rdy, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
endmodule

bind brake_step_interpolator bsi_checker u_bsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives speed/pedal beats into the brake step interpolator under random
// idling on both channels, and checks each result beat against a predictor
// of the full-step and pedal interpolation over several register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsi_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [14:0] cfg_wdata;

  bsi_stream_if #(.W(31)) in_ch ();
  bsi_stream_if #(.W(15)) out_ch ();

  brake_step_interpolator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // register mirror
  cfg_t regs;

  logic [14:0] step_q[$];
  int          errors;
  bit          long_hold;
  bit          quiet_rx;

  // directed stimulus row
  typedef struct {
    logic signed [15:0] spd;
    logic [14:0]        ped;
    bit                 typed;
    logic [14:0]        want;
  } row_t;

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // floor of a Q15 product
  function automatic longint q15_floor(longint x);
    return x >>> 15;
  endfunction

  // full-brake step for a signed speed
  function automatic longint full_brake(longint s);
    longint lo, hi, ls, hs, k, c;
    lo = longint'(regs.low_speed);
    hi = longint'(regs.high_speed);
    ls = longint'(regs.low_full);
    hs = longint'(regs.high_full);
    if (s >= 0) begin
      if (s < lo) return ls;
      if (s > hi) return hs;
    end else begin
      if (s > -lo) return ls;
      if (s < -hi) return hs;
    end
    if (hi == lo) return ls;
    k = ((hs - ls) * 32768) / (hi - lo);
    c = (ls * hi - hs * lo) / (hi - lo);
    if (s < 0) k = -k;
    return q15_floor(k * s) + c;
  endfunction

  // drive step for one beat
  function automatic logic [14:0] drive_step(logic signed [15:0] spd, logic [14:0] ped);
    longint base, d, t, r;
    base = longint'(regs.idle_step);
    if (ped < PedalThreshold) begin
      r = base;
    end else begin
      d = full_brake(longint'(spd)) - base;
      t = (d * 32768) / longint'(PedalSpan);
      r = q15_floor(t * (longint'(ped) - longint'(PedalThreshold))) + base;
    end
    if (r < 0) r = 0;
    if (r > longint'(StepMax)) r = longint'(StepMax);
    return r[14:0];
  endfunction

  // write all five registers, one per cycle
  task automatic load_regs(cfg_t c);
    reg_idx_t idx[5];
    logic [14:0] val[5];
    idx = '{REG_LOW_SPEED, REG_HIGH_SPEED, REG_LOW_FULL, REG_HIGH_FULL, REG_IDLE_STEP};
    val = '{c.low_speed, c.high_speed, c.low_full, c.high_full, c.idle_step};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
  endtask

  // one input beat with a random gap ahead of it
  task automatic send_beat(logic signed [15:0] spd, logic [14:0] ped, bit typed,
                           logic [14:0] want);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {ped, spd};
    do @(posedge clk); while (!in_ch.ready);
    step_q.push_back(typed ? want : drive_step(spd, ped));
  endtask

  // wait until every expected beat is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (step_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_speed();
    logic [14:0] m;
    case ($urandom_range(0, 5))
      0: m = 15'(regs.low_speed + $urandom_range(0, 4) - 2);
      1: m = 15'(regs.high_speed + $urandom_range(0, 4) - 2);
      2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      default: return 16'($urandom);
    endcase
    return $urandom_range(0, 1) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [14:0] pick_pedal();
    case ($urandom_range(0, 7))
      0: return 15'($urandom_range(0, 327));
      1: return 15'(328 + $urandom_range(0, 1));
      2: return 15'h7fff;
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_regs(int phase);
    cfg_t c;
    c.low_full  = 15'($urandom);
    c.high_full = 15'($urandom);
    c.idle_step = 15'($urandom);
    c.low_speed = 15'($urandom_range(0, 16000));
    c.high_speed = 15'(c.low_speed + $urandom_range(1, 16000));
    case (phase)
      0: c = '{default: 15'h7fff};
      1: begin c = '0; c.high_full = 15'h7fff; end
      2: c.high_speed = c.low_speed;
      3: begin c.low_speed = 15'd20000; c.high_speed = 15'd300; end
      4: begin c.low_full = '0; c.high_full = '0; c.idle_step = 15'h7fff; end
      default: ;
    endcase
    return c;
  endfunction

  // result checker with random stalls
  initial begin
    int wait_n;
    logic [14:0] want;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_n = quiet_rx ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (step_q.size() == 0) begin
        $display("%0t: unexpected beat, got step_out=%0d", $time, out_ch.data);
        errors++;
      end else begin
        want = step_q.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: step_out expected %0d actual %0d", $time, want, out_ch.data);
          errors++;
        end
      end
    end
  end

  // watchdog on stalled handshakes
  initial begin
    int idle_n;
    idle_n = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_n = 0;
      else idle_n++;
      if (idle_n >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    row_t reset_rows[8];
    row_t dir_rows[14];
    cfg_t dir_cfg;
    errors = 0;
    long_hold = 1'b0;
    quiet_rx = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_LOW_SPEED;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    regs = '{low_speed: 15'd0, high_speed: 15'h7fff, low_full: 15'd0, high_full: 15'd0,
             idle_step: 15'd0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: every step is zero
    reset_rows = '{
      '{16'sh0000, 15'h0000, 1'b1, 15'd0}, '{16'sh7fff, 15'h7fff, 1'b1, 15'd0},
      '{16'sh8000, 15'h7fff, 1'b1, 15'd0}, '{-16'sd1, 15'd328, 1'b1, 15'd0},
      '{16'sd1, 15'd327, 1'b1, 15'd0},     '{16'sh5555, 15'h2aaa, 1'b1, 15'd0},
      '{16'shaaaa, 15'h5555, 1'b1, 15'd0}, '{16'sd100, 15'd329, 1'b1, 15'd0}};
    foreach (reset_rows[i])
      send_beat(reset_rows[i].spd, reset_rows[i].ped, reset_rows[i].typed, reset_rows[i].want);
    drain();

    // one interpolating setting; pedal below threshold gives the idle step
    dir_cfg = '{low_speed: 15'd1000, high_speed: 15'd20000, low_full: 15'd2000,
                high_full: 15'd30000, idle_step: 15'd500};
    load_regs(dir_cfg);
    dir_rows = '{
      '{16'sd0, 15'd0, 1'b1, 15'd500},         '{16'sh8000, 15'd327, 1'b1, 15'd500},
      '{16'sd999, 15'h7fff, 1'b0, 15'd0},      '{16'sd1000, 15'h7fff, 1'b0, 15'd0},
      '{16'sd20000, 15'h7fff, 1'b0, 15'd0},    '{16'sd20001, 15'h7fff, 1'b0, 15'd0},
      '{-16'sd999, 15'h7fff, 1'b0, 15'd0},     '{-16'sd1000, 15'h7fff, 1'b0, 15'd0},
      '{-16'sd20000, 15'h7fff, 1'b0, 15'd0},   '{-16'sd20001, 15'd328, 1'b0, 15'd0},
      '{16'sh7fff, 15'd328, 1'b0, 15'd0},      '{16'sh8000, 15'h7fff, 1'b0, 15'd0},
      '{16'sd12345, 15'd16000, 1'b0, 15'd0},   '{-16'sd7777, 15'd20000, 1'b0, 15'd0}};
    foreach (dir_rows[i])
      send_beat(dir_rows[i].spd, dir_rows[i].ped, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // random phases over varied settings
    for (int ph = 0; ph < 8; ph++) begin
      load_regs(pick_regs(ph));
      quiet_rx = (ph == 6);
      if (ph == 2) long_hold = 1'b1;
      for (int n = 0; n < 75; n++) send_beat(pick_speed(), pick_pedal(), 1'b0, 15'd0);
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
